// ===== rtl/core/kah_pkg.sv =====
// Package for the key activity heat map: sizes, register indexes, modes and colour helpers.
// Depends on nothing; used by every module under rtl/core except kah_divider.
`default_nettype none
package kah_pkg;
   localparam int unsigned MaxRows    = 4;
   localparam int unsigned MaxCols    = 16;
   localparam int unsigned Entries    = MaxRows * MaxCols;
   localparam int unsigned IdxW       = 6;
   localparam int unsigned DefRows    = 4;
   localparam int unsigned DefCols    = 16;

   localparam logic [15:0] UpdFreqRst   = 16'd1;
   localparam logic [7:0]  PeakLimRst   = 8'd191;
   localparam logic [15:0] TotalLimRst  = 16'd16000;

   localparam logic [1:0] RegUpdFreq  = 2'd0;
   localparam logic [1:0] RegPeakLim  = 2'd1;
   localparam logic [1:0] RegTotalLim = 2'd2;

   localparam logic [1:0] ModeKey    = 2'd0;
   localparam logic [1:0] ModeLoop   = 2'd1;
   localparam logic [1:0] ModeRender = 2'd2;

   typedef struct packed {
      logic clear_step;
      logic load_key;
      logic key_inc;
      logic halve_step;
      logic halve_done;
      logic div_start;
      logic emit;
      logic load_idx;
      logic next_idx;
   } kah_cmd_type;

   typedef struct packed {
      logic over_limit;
      logic div_done;
      logic idx_last;
   } kah_stat_type;

   // tenths value of a stop for a channel
   function automatic logic [3:0] stop_val(input logic [1:0] s, input logic [1:0] ch);
      logic [3:0] v;
      v = 4'd3;
      unique case (s)
         2'd0: v = 4'd3;
         2'd1: v = (ch == 2'd1) ? 4'd10 : 4'd3;
         2'd2: v = (ch == 2'd2) ? 4'd3 : 4'd10;
         default: v = (ch == 2'd0) ? 4'd10 : 4'd3;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/kah_divider.sv =====
// Restoring divider for the fraction count*3*65536 / total, one quotient bit per cycle.
// Does not use kah_pkg; standalone.
`default_nettype none
module kah_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [25:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [17:0]      quotient
);
   logic [25:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [17:0] diff;

   always_comb begin
      trial   = {rem_ff[15:0], quo_ff[25]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = 5'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[17]) begin
            rem_in = diff[16:0];
            quo_in = {quo_ff[24:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[24:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd25) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) den_ff <= divisor;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[17:0];
endmodule
`default_nettype wire

// ===== rtl/core/kah_datapath.sv =====
// Datapath of the heat map: count table, total, peak, sweep index, colour output.
// Depends on kah_pkg and kah_divider.
`default_nettype none
module kah_datapath #(
   parameter int unsigned KEY_ROWS = kah_pkg::DefRows,
   parameter int unsigned KEY_COLS = kah_pkg::DefCols
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kah_pkg::kah_cmd_type cmd,
   output kah_pkg::kah_stat_type     stat,
   input  wire logic [1:0]           key_row,
   input  wire logic [3:0]           key_col,
   input  wire logic [7:0]           peak_limit,
   input  wire logic [15:0]          total_limit,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_led_row,
   output logic [3:0]                rsp_led_col,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic                      rsp_last
);
   localparam logic [1:0] LastRow = 2'(KEY_ROWS - 1);
   localparam logic [3:0] LastCol = 4'(KEY_COLS - 1);

   logic [7:0]  cnt_mem [kah_pkg::Entries];
   logic [15:0] total_ff;
   logic [7:0]  peak_ff;
   logic [15:0] sum_ff;
   logic [7:0]  hpk_ff;
   logic [1:0]  row_ff;
   logic [3:0]  col_ff;
   logic [7:0]  rd_ff;
   logic [5:0]  key_idx, swp_idx, rd_addr;
   logic [7:0]  half;
   logic [16:0] sum_add;
   logic [7:0]  kinc;
   logic        key_ok;
   logic [15:0] den;
   logic        dstart_ff;
   logic        ddone;
   logic [17:0] quo;
   logic [1:0]  i1;
   logic [1:0]  i2;
   logic [15:0] frac;
   logic [7:0]  ch [3];
   logic        vld_ff;
   logic [7:0]  r_ff, g_ff, b_ff;
   logic [1:0]  orow_ff;
   logic [3:0]  ocol_ff;
   logic        olast_ff;

   assign key_idx = {key_row, key_col};
   assign swp_idx = {row_ff, col_ff};
   assign rd_addr = cmd.load_key ? key_idx : swp_idx;
   assign half    = rd_ff >> 1;
   assign sum_add = {1'b0, sum_ff} + {9'd0, half};
   assign kinc    = (rd_ff == 8'hFF) ? rd_ff : rd_ff + 8'd1;
   assign key_ok  = cmd.key_inc && (row_ff <= LastRow) && (col_ff <= LastCol);
   assign den     = (total_ff == 16'd0) ? 16'd1 : total_ff;

   kah_divider u_div (
      .clock(clock), .reset(reset), .start(dstart_ff),
      .dividend({1'b0, rd_ff, 17'd0} + {2'b00, rd_ff, 16'd0}),
      .divisor(den), .done(ddone), .quotient(quo)
   );

   always_comb begin
      i1   = 2'd0;
      i2   = 2'd0;
      frac = 16'd0;
      if (rd_ff == 8'd0) begin
         i1 = 2'd0;
         i2 = 2'd0;
      end else if ({8'd0, rd_ff} >= den) begin
         i1 = 2'd3;
         i2 = 2'd3;
      end else begin
         i1   = (quo[17:16] > 2'd2) ? 2'd2 : quo[17:16];
         i2   = i1 + 2'd1;
         frac = quo[15:0];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_ch
      logic signed [5:0]  a_s, b_s;
      logic signed [22:0] num, num_ff;
      logic [27:0]        prod;
      logic [11:0]        tens;
      logic [27:0]        scl;
      always_comb begin
         a_s  = $signed({2'b00, kah_pkg::stop_val(i1, 2'(k))});
         b_s  = $signed({2'b00, kah_pkg::stop_val(i2, 2'(k))});
         num  = $signed({a_s, 16'd0}) + 23'((b_s - a_s) * $signed({1'b0, frac}));
         prod = 28'(num_ff[21:0]) * 28'd255;
         tens = prod[27:16];
         scl  = 28'(tens) * 28'd52429;
         ch[k] = (num_ff < 0) ? 8'd0 : scl[26:19];
      end
      always_ff @(posedge clock) begin
         num_ff <= num;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= cnt_mem[rd_addr];
      if (cmd.clear_step) begin
         cnt_mem[swp_idx] <= 8'd0;
      end else if (key_ok) begin
         cnt_mem[swp_idx] <= kinc;
      end else if (cmd.halve_step) begin
         cnt_mem[swp_idx] <= half;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 2'd0;
         col_ff <= 4'd0;
      end else if (cmd.load_idx) begin
         row_ff <= 2'd0;
         col_ff <= 4'd0;
      end else if (cmd.load_key) begin
         row_ff <= key_row;
         col_ff <= key_col;
      end else if (cmd.next_idx) begin
         if (col_ff == LastCol) begin
            col_ff <= 4'd0;
            row_ff <= row_ff + 2'd1;
         end else begin
            col_ff <= col_ff + 4'd1;
         end
      end
      if (cmd.load_idx) begin
         sum_ff <= 16'd0;
         hpk_ff <= 8'd0;
      end else if (cmd.halve_step) begin
         sum_ff <= sum_add[16] ? 16'hFFFF : sum_add[15:0];
         if (half > hpk_ff) hpk_ff <= half;
      end
      r_ff     <= ch[0];
      g_ff     <= ch[1];
      b_ff     <= ch[2];
      orow_ff  <= row_ff;
      ocol_ff  <= col_ff;
      olast_ff <= stat.idx_last;
      if (reset) begin
         total_ff  <= 16'd0;
         peak_ff   <= 8'd0;
         vld_ff    <= 1'b0;
         dstart_ff <= 1'b0;
      end else begin
         vld_ff    <= cmd.emit;
         dstart_ff <= cmd.div_start;
         if (key_ok) begin
            if (total_ff != 16'hFFFF) total_ff <= total_ff + 16'd1;
            if (kinc > peak_ff) peak_ff <= kinc;
         end else if (cmd.halve_done) begin
            total_ff <= sum_ff;
            peak_ff  <= hpk_ff;
         end
      end
   end

   assign stat.over_limit = (peak_ff > peak_limit) || (total_ff > total_limit);
   assign stat.div_done   = ddone;
   assign stat.idx_last   = (row_ff == LastRow) && (col_ff == LastCol);

   assign rsp_valid   = vld_ff;
   assign rsp_led_row = orow_ff;
   assign rsp_led_col = ocol_ff;
   assign rsp_red     = r_ff;
   assign rsp_green   = g_ff;
   assign rsp_blue    = b_ff;
   assign rsp_last    = olast_ff;
endmodule
`default_nettype wire

// ===== rtl/core/kah_control.sv =====
// Controller of the heat map: clear sweep, key update, halving sweep, render sweep.
// Depends on kah_pkg.
`default_nettype none
module kah_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            mode,
   input  wire logic                  is_synthetic,
   input  wire logic                  fresh_press,
   input  wire logic [1:0]            key_row,
   input  wire logic [3:0]            key_col,
   input  wire logic [15:0]           update_frequency,
   input  wire kah_pkg::kah_stat_type stat,
   output kah_pkg::kah_cmd_type       cmd,
   output logic                       busy
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_K_WR, ST_H_RD, ST_H_WR, ST_H_END,
      ST_R_RD, ST_R_DIV, ST_R_WAIT, ST_R_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] frame_ff, frame_in;
   logic [15:0] fnext;
   logic        accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign fnext  = frame_ff + 16'd1;

   always_comb begin
      state_in = state_ff;
      frame_in = frame_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            cmd.next_idx   = 1'b1;
            if (stat.idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               priority if (mode == kah_pkg::ModeKey) begin
                  if (fresh_press &&
                      !(is_synthetic && key_row == 2'd0 && key_col == 4'd0)) begin
                     cmd.load_key = 1'b1;
                     state_in     = ST_K_WR;
                  end
               end else if (mode == kah_pkg::ModeLoop) begin
                  if (stat.over_limit) begin
                     cmd.load_idx = 1'b1;
                     state_in     = ST_H_RD;
                  end
               end else if (mode == kah_pkg::ModeRender) begin
                  if (fnext < update_frequency) begin
                     frame_in = fnext;
                  end else begin
                     frame_in     = 16'd0;
                     cmd.load_idx = 1'b1;
                     state_in     = ST_R_RD;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_K_WR: begin
            cmd.key_inc = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_H_RD: state_in = ST_H_WR;
         ST_H_WR: begin
            cmd.halve_step = 1'b1;
            cmd.next_idx   = !stat.idx_last;
            state_in       = stat.idx_last ? ST_H_END : ST_H_RD;
         end
         ST_H_END: begin
            cmd.halve_done = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_R_RD: state_in = ST_R_DIV;
         ST_R_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_R_WAIT;
         end
         ST_R_WAIT: if (stat.div_done) state_in = ST_R_EMIT;
         ST_R_EMIT: begin
            cmd.emit     = 1'b1;
            cmd.next_idx = !stat.idx_last;
            state_in     = stat.idx_last ? ST_IDLE : ST_R_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         frame_ff <= 16'd0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/key_activity_heatmap_core.sv =====
// Key activity heat map top level: controller, datapath and configuration registers.
// Key items pass through ST_K_WR when counted and are dropped in ST_IDLE; loop items
// sweep ST_H_RD and ST_H_WR per key, then ST_H_END, when halving; one item in flight at a time.
// Every update_frequency-th render item emits one colour per key, each after a divider run.
// Results are strobed on rsp_valid for one cycle; the receiver cannot stall.
// Synchronous reset; the count table is then cleared key by key in ST_CLEAR, busy high.
`default_nettype none
module key_activity_heatmap_core #(
   parameter int unsigned KEY_ROWS = kah_pkg::DefRows,
   parameter int unsigned KEY_COLS = kah_pkg::DefCols
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [1:0]  req_key_row,
   input  wire logic [3:0]  req_key_col,
   input  wire logic        req_is_synthetic,
   input  wire logic        req_fresh_press,
   output logic             rsp_valid,
   output logic [1:0]       rsp_led_row,
   output logic [3:0]       rsp_led_col,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   kah_pkg::kah_cmd_type  cmd;
   kah_pkg::kah_stat_type stat;
   logic [15:0] upd_ff;
   logic [7:0]  plim_ff;
   logic [15:0] tlim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff  <= kah_pkg::UpdFreqRst;
         plim_ff <= kah_pkg::PeakLimRst;
         tlim_ff <= kah_pkg::TotalLimRst;
      end else if (csr_valid) begin
         if (csr_index == kah_pkg::RegUpdFreq)  upd_ff  <= csr_wdata;
         if (csr_index == kah_pkg::RegPeakLim)  plim_ff <= csr_wdata[7:0];
         if (csr_index == kah_pkg::RegTotalLim) tlim_ff <= csr_wdata;
      end
   end

   kah_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .mode(req_mode),
      .is_synthetic(req_is_synthetic), .fresh_press(req_fresh_press),
      .key_row(req_key_row), .key_col(req_key_col),
      .update_frequency(upd_ff), .stat(stat), .cmd(cmd), .busy(busy)
   );

   kah_datapath #(.KEY_ROWS(KEY_ROWS), .KEY_COLS(KEY_COLS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .key_row(req_key_row), .key_col(req_key_col),
      .peak_limit(plim_ff), .total_limit(tlim_ff),
      .rsp_valid(rsp_valid), .rsp_led_row(rsp_led_row), .rsp_led_col(rsp_led_col),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire
